/* rtl/arleb_pkg.sv */
`timescale 1ns / 1ps
package arleb_pkg;

	localparam int BLOCK_BYTES = 1024;
	localparam int OFS_W = $clog2(BLOCK_BYTES + 1);
	localparam int LEN_W = 5;
	localparam int CNT_W = 11;

	localparam logic [1:0] TK_PS = 2'd0;
	localparam logic [1:0] TK_PO = 2'd1;
	localparam logic [1:0] TK_GE = 2'd2;

	localparam logic [1:0] OK_BYTE = 2'd0;
	localparam logic [1:0] OK_START = 2'd1;
	localparam logic [1:0] OK_SUMMARY = 2'd2;
	localparam logic [1:0] OK_ERROR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NONCONTIG = 2'd1;
	localparam logic [1:0] ST_UNEQUAL = 2'd2;

	localparam logic CFG_KIND = 1'b0;
	localparam logic CFG_WIDE = 1'b1;

	typedef struct packed {
		logic       load_in;
		logic       open_blk;
		logic       merge;
		logic       enc_start;
		logic       zero_delta;
		logic       enc_step;
		logic       count;
		logic       emit_byte;
		logic       out_load;
		logic [1:0] out_kind;
		logic       out_last;
	} arleb_cmd_t;

	typedef struct packed {
		logic [1:0] err;
		logic       block_open;
		logic       enc_done;
		logic       overflow;
		logic       out_free;
	} arleb_sts_t;

	// Difference as signed at the active width, sign-extended to 64 bits.
	function automatic logic [63:0] sdiff(input logic [63:0] a, input logic [63:0] b,
			input logic wide);
		logic [63:0] d;
		d = a - b;
		if (!wide)
			d = {{32{d[31]}}, d[31:0]};
		return d;
	endfunction

	function automatic logic [63:0] asr2(input logic [63:0] v);
		return {{2{v[63]}}, v[63:2]};
	endfunction

endpackage

/* rtl/arleb_ctrl.sv */
`timescale 1ns / 1ps
module arleb_ctrl
	import arleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  arleb_sts_t sts,
	output arleb_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_ERR, S_START, S_COUNT, S_DECIDE, S_SUM, S_EMIT
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.err != ST_OK) begin
					state_d = S_ERR;
				end else if (!sts.block_open) begin
					state_d = S_START;
				end else begin
					cmd.enc_start = 1'b1;
					state_d = S_COUNT;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_ERROR;
					cmd.out_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_START: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_START;
					cmd.open_blk = 1'b1;
					cmd.enc_start = 1'b1;
					cmd.zero_delta = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_COUNT: begin
				// Dry run of the encoder to learn the entry length.
				cmd.enc_step = 1'b1;
				cmd.count = 1'b1;
				if (sts.enc_done)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.overflow) begin
					state_d = S_SUM;
				end else begin
					cmd.merge = 1'b1;
					cmd.enc_start = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_SUM: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_SUMMARY;
					state_d = S_START;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.enc_step = 1'b1;
					cmd.emit_byte = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_BYTE;
					cmd.out_last = sts.enc_done;
					if (sts.enc_done)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* rtl/arleb_dp.sv */
`timescale 1ns / 1ps
module arleb_dp
	import arleb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [1:0]        cfg_wdata,
	input  logic [63:0]       new_address,
	input  logic [63:0]       new_length,
	input  logic [63:0]       old_address,
	input  logic [63:0]       old_length,
	input  arleb_cmd_t        cmd,
	output arleb_sts_t        sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        data_byte,
	output logic [63:0]       low_new,
	output logic [63:0]       low_old,
	output logic [63:0]       high_new,
	output logic [63:0]       high_old,
	output logic [CNT_W-1:0]  entry_count,
	output logic [1:0]        status,
	output logic              last
);

	logic [1:0]       tkind_q;
	logic             wide_q;
	logic [63:0]      na_q, nl_q, oa_q, ol_q;
	logic [63:0]      pna_q, pnl_q, poa_q, pol_q;
	logic [63:0]      ext_q [4];
	logic             open_q;
	logic [OFS_W-1:0] ofs_q;
	logic [CNT_W-1:0] ent_q;
	logic [63:0]      v_q;
	logic [1:0]       fld_q;
	logic [63:0]      dlt_q;
	logic [LEN_W-1:0] len_q;

	logic        is_ps, is_po, is_ge;
	logic [1:0]  err_c;
	logic [63:0] m, na_m, nl_m, oa_m, ol_m, ne, oe;
	logic [63:0] f1, f2, sh;
	logic [6:0]  b7;
	logic        sgn, step_last, more_fld;
	logic [OFS_W:0] tot;

	assign is_po = (tkind_q == TK_PO);
	assign is_ge = (tkind_q == TK_GE);
	assign is_ps = !is_po && !is_ge;
	assign m = wide_q ? '1 : 64'h0000_0000_FFFF_FFFF;
	assign na_m = new_address & m;
	assign nl_m = new_length & m;
	assign oa_m = old_address & m;
	assign ol_m = old_length & m;
	assign ne = (na_q + nl_q) & m;
	assign oe = (oa_q + ol_q) & m;

	always_comb begin
		err_c = ST_OK;
		if (!open_q) begin
			if (is_ps && nl_q != ol_q)
				err_c = ST_UNEQUAL;
		end else if (na_q != ((pna_q + pnl_q) & m)) begin
			err_c = ST_NONCONTIG;
		end else if (is_po && oa_q != ((poa_q + pol_q) & m)) begin
			err_c = ST_NONCONTIG;
		end else if (is_ps && nl_q != ol_q) begin
			err_c = ST_UNEQUAL;
		end
	end

	// Serial LEB128 encoder: one byte of the current field each step.
	// The old-address delta is captured at encoder start, before the previous
	// range is replaced.
	assign f1 = is_po ? {2'b00, ol_q[63:2]} : dlt_q;
	assign f2 = asr2(sdiff(nl_q, ol_q, wide_q));
	assign sgn = (fld_q == 2'd1 && !is_po) || (fld_q == 2'd2);
	assign b7 = v_q[6:0];
	assign sh = sgn ? {{7{v_q[63]}}, v_q[63:7]} : {7'd0, v_q[63:7]};
	assign step_last = sgn ? ((sh == '0 && !b7[6]) || (&sh && b7[6])) : (sh == '0);
	assign more_fld = (fld_q == 2'd0) || (fld_q == 2'd1 && is_ge);
	assign tot = {1'b0, ofs_q} + {{(OFS_W + 1 - LEN_W){1'b0}}, len_q};

	assign sts.err = err_c;
	assign sts.block_open = open_q;
	assign sts.enc_done = step_last && !more_fld;
	assign sts.overflow = tot > (OFS_W + 1)'(BLOCK_BYTES);
	assign sts.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tkind_q <= TK_PS;
			wide_q <= 1'b1;
			open_q <= 1'b0;
			pna_q <= '0;
			pnl_q <= '0;
			poa_q <= '0;
			pol_q <= '0;
			ext_q[0] <= '0;
			ext_q[1] <= '0;
			ext_q[2] <= '0;
			ext_q[3] <= '0;
			ofs_q <= '0;
			ent_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KIND: tkind_q <= cfg_wdata;
					CFG_WIDE: wide_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.open_blk) begin
				open_q <= 1'b1;
				ext_q[0] <= na_q;
				ext_q[1] <= oa_q;
				ext_q[2] <= ne;
				ext_q[3] <= oe;
				pna_q <= na_q;
				pnl_q <= nl_q;
				poa_q <= oa_q;
				pol_q <= ol_q;
				ofs_q <= '0;
				ent_q <= CNT_W'(1);
			end else if (cmd.merge) begin
				if (ext_q[0] > na_q) ext_q[0] <= na_q;
				if (ext_q[1] > oa_q) ext_q[1] <= oa_q;
				if (ext_q[2] < ne) ext_q[2] <= ne;
				if (ext_q[3] < oe) ext_q[3] <= oe;
				pna_q <= na_q;
				pnl_q <= nl_q;
				poa_q <= oa_q;
				pol_q <= ol_q;
				if (ent_q != '1)
					ent_q <= ent_q + CNT_W'(1);
			end else if (cmd.emit_byte) begin
				ofs_q <= ofs_q + OFS_W'(1);
			end
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			na_q <= na_m;
			nl_q <= nl_m;
			oa_q <= oa_m;
			ol_q <= ol_m;
		end
		if (cmd.enc_start) begin
			v_q <= {2'b00, nl_q[63:2]};
			fld_q <= 2'd0;
			dlt_q <= cmd.zero_delta ? 64'd0 : asr2(sdiff(oa_q, poa_q, wide_q));
			len_q <= '0;
		end else if (cmd.enc_step) begin
			if (step_last && fld_q == 2'd0) begin
				v_q <= f1;
				fld_q <= 2'd1;
			end else if (step_last && fld_q == 2'd1 && is_ge) begin
				v_q <= f2;
				fld_q <= 2'd2;
			end else begin
				v_q <= sh;
			end
			if (cmd.count)
				len_q <= len_q + LEN_W'(1);
		end
		if (cmd.out_load) begin
			kind <= cmd.out_kind;
			last <= cmd.out_last;
			data_byte <= '0;
			low_new <= '0;
			low_old <= '0;
			high_new <= '0;
			high_old <= '0;
			entry_count <= '0;
			status <= ST_OK;
			case (cmd.out_kind)
				OK_BYTE: data_byte <= {~step_last, b7};
				OK_START: begin
					low_new <= na_q;
					low_old <= oa_q;
				end
				OK_SUMMARY: begin
					low_new <= ext_q[0];
					low_old <= ext_q[1];
					high_new <= ext_q[2];
					high_old <= ext_q[3];
					entry_count <= ent_q;
				end
				default: status <= err_c;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ofs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> ({1'b0, ofs_q} <= (OFS_W + 1)'(BLOCK_BYTES)))
		else $error("block byte offset exceeds the block size");
	a_ent_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (ent_q != '0))
		else $error("open block holds no entries");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count |-> (len_q < LEN_W'(30)))
		else $error("entry longer than thirty bytes");
`endif

endmodule

/* rtl/address_range_leb128_block_encoder_core.sv */
`timescale 1ns / 1ps
// Sequence: an accepted request is registered, then checked against the open block.
// Then an error result is loaded, or a block start record and the entry bytes, or, on
// an open block, a run of the serial encoder to size the entry, a fit decision (a
// summary and a new block on overflow) and a second run that emits the entry bytes.
// Throughput: one request at a time; each output load waits for a free output register.
// Reset (arst_n low) clears the block state and sets table_kind 0, wide_addresses 1.
module address_range_leb128_block_encoder_core
	import arleb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [1:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       new_address,
	input  logic [63:0]       new_length,
	input  logic [63:0]       old_address,
	input  logic [63:0]       old_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        data_byte,
	output logic [63:0]       low_new,
	output logic [63:0]       low_old,
	output logic [63:0]       high_new,
	output logic [63:0]       high_old,
	output logic [CNT_W-1:0]  entry_count,
	output logic [1:0]        status,
	output logic              last
);

	arleb_cmd_t cmd;
	arleb_sts_t sts;

	arleb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arleb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.new_address (new_address),
		.new_length  (new_length),
		.old_address (old_address),
		.old_length  (old_length),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.low_new     (low_new),
		.low_old     (low_old),
		.high_new    (high_new),
		.high_old    (high_old),
		.entry_count (entry_count),
		.status      (status),
		.last        (last)
	);

endmodule
